// ----- rtl/buffer_pool_pin_manager_core_assert.svh -----
// ----------------------------------------------------------------------------
// buffer_pool_pin_manager_core assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_PIN_MANAGER_CORE_ASSERT_SVH
`define BUFFER_POOL_PIN_MANAGER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// plain property, checked at every edge out of reset
`define BPM_ASSERT(lbl, clock, rst_n, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define BPM_ASSERT_IMP(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPM_ASSERT_NXT(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BPM_ASSERT(lbl, clock, rst_n, prop, msg)
`define BPM_ASSERT_IMP(lbl, clock, rst_n, ante, cons, msg)
`define BPM_ASSERT_NXT(lbl, clock, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpm_pkg
// shared types, codes and field widths of the buffer pool pin manager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpm_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int TAG_BITS_DEF  = 48;
	localparam int PIN_MAX_DEF   = 255;

	localparam int TAG_FIELD_W  = 48;
	localparam int IDX_FIELD_W  = 3;
	localparam int SLOT_FIELD_W = 3;
	localparam int STAT_W       = 2;
	localparam int AVAIL_W      = 4;
	localparam int S_TDATA_W    = 56;
	localparam int M_TDATA_W    = 16;
	localparam int M_PAD_W      = M_TDATA_W - SLOT_FIELD_W - STAT_W - 2 - AVAIL_W;

	typedef enum logic {
		FUNC_PIN   = 1'b0,
		FUNC_UNPIN = 1'b1
	} bpm_func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_NOT_PIN  = 2'd2,
		STAT_SAT      = 2'd3
	} bpm_status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_LOOK = 1'b1
	} bpm_state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic      go;
		bpm_func_t func;
		logic      any_hit;
	} bpm_cmd_t;

	// per-cell flags gathered by the controller
	typedef struct packed {
		logic match;
		logic hit_first;
		logic hit_max;
		logic hit_zero;
		logic free_first;
		logic sel_live;
		logic sel_one;
		logic pins_zero;
	} bpm_flags_t;

endpackage

// ----- rtl/bpm_cell.sv -----
// ----------------------------------------------------------------------------
// bpm_cell
// one buffer slot: valid mark, tag and pin count, with priority chain links
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_cell
	import bpm_pkg::*;
#(
	parameter int INDEX    = 0,
	parameter int TAG_BITS = TAG_BITS_DEF,
	parameter int PIN_MAX  = PIN_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bpm_cmd_t               cmd,
	input  logic [TAG_BITS-1:0]    tag,
	input  logic [IDX_FIELD_W-1:0] idx,
	input  logic                   hit_in,
	input  logic                   free_in,
	output logic                   hit_out,
	output logic                   free_out,
	output bpm_flags_t             flags
);

	localparam int PIN_W = $clog2(PIN_MAX + 1);

	logic                valid_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [PIN_W-1:0]    pins_q;

	logic match;
	logic free_here;
	logic sel;
	logic at_max;
	logic take;

	assign match     = valid_q && (tag_q == tag);
	assign free_here = (pins_q == '0);
	assign sel       = (32'(INDEX) == 32'(idx));
	assign at_max    = (pins_q == PIN_W'(PIN_MAX));

	// lowest-numbered cell wins; the chain carries "someone below already has it"
	assign hit_out  = hit_in | match;
	assign free_out = free_in | free_here;

	always_comb begin
		flags.match      = match;
		flags.hit_first  = match && !hit_in;
		flags.hit_max    = match && !hit_in && at_max;
		flags.hit_zero   = match && !hit_in && free_here;
		flags.free_first = free_here && !free_in;
		flags.sel_live   = sel && !free_here;
		flags.sel_one    = sel && (pins_q == PIN_W'(1));
		flags.pins_zero  = free_here;
	end

	assign take = cmd.go && (cmd.func == FUNC_PIN) && !cmd.any_hit && free_here && !free_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pins_q  <= '0;
		end else if (cmd.go) begin
			if (cmd.func == FUNC_PIN) begin
				if (match && !hit_in && !at_max) begin
					pins_q <= PIN_W'(pins_q + 1'b1);
				end else if (take) begin
					valid_q <= 1'b1;
					pins_q  <= PIN_W'(1);
				end
			end else if (sel && !free_here) begin
				pins_q <= PIN_W'(pins_q - 1'b1);
			end
		end
	end

	// retag on a miss
	always_ff @(posedge clk) begin
		if (take) begin
			tag_q <= tag;
		end
	end

endmodule

// ----- rtl/buffer_pool_pin_manager_core.sv -----
// ----------------------------------------------------------------------------
// buffer_pool_pin_manager_core
// pin/unpin manager over a row of buffer slot cells
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                                         | tuser
//  ----------+-----+-----------------------------------------------+------
//  s_*       | in  | block_tag[47:0], slot_index[50:48]            | func
//  m_*       | out | slot[2:0], status[4:3], hit[5], needs_load[6],| -
//            |     | available_count[10:7]                         |
//
//  every request passes the idle state that accepts it, then the lookup state for the
//  tag compare and priority chain across all cells, which also updates the cells
//  the result is valid in the output register right after the lookup cycle
//  while a result is not taken one more transfer is accepted, which then
//  holds in the lookup cycle until the output register frees up
//  reset empties every slot and sets the available count to NUM_SLOTS
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "buffer_pool_pin_manager_core_assert.svh"

module buffer_pool_pin_manager_core
	import bpm_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TAG_BITS  = TAG_BITS_DEF,
	parameter int PIN_MAX   = PIN_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // block_tag, slot_index, zero pad
	input  logic                 s_tuser,  // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // slot, status, hit, needs_load, available_count, pad
);

	localparam int IW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int FREE_W = $clog2(NUM_SLOTS + 1);

	bpm_state_t state_q;
	bpm_state_t state_nxt;
	logic       go;

	bpm_func_t              req_func_q;
	logic [TAG_BITS-1:0]    req_tag_q;
	logic [IDX_FIELD_W-1:0] req_idx_q;
	logic [FREE_W-1:0]      free_q;
	logic [FREE_W-1:0]      free_nxt;

	logic                 m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	logic [NUM_SLOTS:0]     hit_chain;
	logic [NUM_SLOTS:0]     free_chain;
	bpm_flags_t             flags [NUM_SLOTS];
	bpm_cmd_t               cmd;
	logic [NUM_SLOTS-1:0]   match_vec;
	logic [NUM_SLOTS-1:0]   zero_vec;

	logic [IW-1:0]      hit_idx;
	logic [IW-1:0]      free_idx;
	logic               hit_max;
	logic               hit_zero;
	logic               sel_live;
	logic               sel_one;
	logic [SLOT_FIELD_W-1:0] res_slot;
	bpm_status_t        res_stat;
	logic               res_hit;
	logic               res_load;

	// ---------------- control ----------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_LOOK;
			ST_LOOK: if (!m_valid_q || m_tready) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		go       = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_LOOK: go = !m_valid_q || m_tready;
			default: begin
				s_tready = 1'b0;
				go       = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_func_q <= bpm_func_t'(s_tuser);
			req_tag_q  <= TAG_BITS'(s_tdata[TAG_FIELD_W-1:0]);
			req_idx_q  <= s_tdata[TAG_FIELD_W +: IDX_FIELD_W];
		end
	end

	// ---------------- slot cells ----------------
	assign hit_chain[0]  = 1'b0;
	assign free_chain[0] = 1'b0;

	always_comb begin
		cmd.go      = go;
		cmd.func    = req_func_q;
		cmd.any_hit = hit_chain[NUM_SLOTS];
	end

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		bpm_cell #(
			.INDEX    (g),
			.TAG_BITS (TAG_BITS),
			.PIN_MAX  (PIN_MAX)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.tag      (req_tag_q),
			.idx      (req_idx_q),
			.hit_in   (hit_chain[g]),
			.free_in  (free_chain[g]),
			.hit_out  (hit_chain[g+1]),
			.free_out (free_chain[g+1]),
			.flags    (flags[g])
		);
		assign match_vec[g] = flags[g].match;
		assign zero_vec[g]  = flags[g].pins_zero;
	end

	// ---------------- gather ----------------
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		hit_max  = 1'b0;
		hit_zero = 1'b0;
		sel_live = 1'b0;
		sel_one  = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (flags[i].hit_first)  hit_idx  = hit_idx | IW'(i);
			if (flags[i].free_first) free_idx = free_idx | IW'(i);
			hit_max  = hit_max | flags[i].hit_max;
			hit_zero = hit_zero | flags[i].hit_zero;
			sel_live = sel_live | flags[i].sel_live;
			sel_one  = sel_one | flags[i].sel_one;
		end
	end

	always_comb begin
		res_slot = '0;
		res_stat = STAT_OK;
		res_hit  = 1'b0;
		res_load = 1'b0;
		free_nxt = free_q;
		if (req_func_q == FUNC_UNPIN) begin
			res_slot = SLOT_FIELD_W'(req_idx_q);
			if (!sel_live) begin
				res_stat = STAT_NOT_PIN;
			end else if (sel_one) begin
				free_nxt = FREE_W'(free_q + 1'b1);
			end
		end else if (hit_chain[NUM_SLOTS]) begin
			res_slot = SLOT_FIELD_W'(hit_idx);
			res_hit  = 1'b1;
			if (hit_max) begin
				res_stat = STAT_SAT;
			end else if (hit_zero) begin
				free_nxt = FREE_W'(free_q - 1'b1);
			end
		end else if (free_chain[NUM_SLOTS]) begin
			res_slot = SLOT_FIELD_W'(free_idx);
			res_load = 1'b1;
			free_nxt = FREE_W'(free_q - 1'b1);
		end else begin
			res_stat = STAT_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= FREE_W'(NUM_SLOTS);
		end else if (go) begin
			free_q <= free_nxt;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_data_q <= {M_PAD_W'(0), AVAIL_W'(free_nxt), res_load, res_hit,
				res_stat, res_slot};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// ---------------- checks ----------------
	`BPM_ASSERT(a_free_bound, clk, arst_n, 32'(free_q) <= 32'(NUM_SLOTS), "free count above slot count")
	`BPM_ASSERT(a_free_count, clk, arst_n, $countones(zero_vec) == int'(free_q), "free count out of step with cells")
	`BPM_ASSERT_IMP(a_tag_unique, clk, arst_n, state_q == ST_LOOK, $onehot0(match_vec), "tag held by two slots")
	`BPM_ASSERT_IMP(a_full_ok, clk, arst_n, go && res_stat == STAT_FULL, free_q == '0, "pool full with free slots")
	`BPM_ASSERT_NXT(a_go_idle, clk, arst_n, go, state_q == ST_IDLE && m_valid_q, "result not posted")

endmodule

// ----- tb/bpm_result_checker.sv -----
// ----------------------------------------------------------------------------
// bpm_result_checker
// tracks the slot table from accepted requests and checks every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_result_checker
	import bpm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // block_tag, slot_index, zero pad
	input  logic                 s_tuser,  // func
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,  // slot, status, hit, needs_load, available_count, pad
	output int                   fail_count,
	output int                   pending
);

	localparam int STAT_LSB  = SLOT_FIELD_W;
	localparam int HIT_LSB   = STAT_LSB + STAT_W;
	localparam int LOAD_LSB  = HIT_LSB + 1;
	localparam int AVAIL_LSB = LOAD_LSB + 1;

	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] slot;
		bpm_status_t             status;
		logic                    hit;
		logic                    needs_load;
		logic [AVAIL_W-1:0]      avail;
	} pin_result_t;

	logic                   held     [NUM_SLOTS_DEF];
	logic [TAG_FIELD_W-1:0] held_tag [NUM_SLOTS_DEF];
	int unsigned            pin_count[NUM_SLOTS_DEF];
	int unsigned            unpinned;
	pin_result_t            expected_q[$];

	function automatic pin_result_t make_result(int s, bpm_status_t st, logic h, logic ld);
		pin_result_t r;
		r.slot       = s[SLOT_FIELD_W-1:0];
		r.status     = st;
		r.hit        = h;
		r.needs_load = ld;
		r.avail      = unpinned[AVAIL_W-1:0];
		return r;
	endfunction

	task automatic predict_request(input bpm_func_t op, input logic [TAG_FIELD_W-1:0] tag,
			input logic [IDX_FIELD_W-1:0] idx, output pin_result_t r);
		int hit_at;
		int free_at;
		hit_at  = -1;
		free_at = -1;
		if (op == FUNC_UNPIN) begin
			if (pin_count[idx] == 0) begin
				r = make_result(int'(idx), STAT_NOT_PIN, 1'b0, 1'b0);
			end else begin
				pin_count[idx]--;
				if (pin_count[idx] == 0)
					unpinned++;
				r = make_result(int'(idx), STAT_OK, 1'b0, 1'b0);
			end
		end else begin
			// walk downward so both indexes end on the lowest match
			for (int i = NUM_SLOTS_DEF - 1; i >= 0; i--) begin
				if (held[i] && held_tag[i] == tag)
					hit_at = i;
				if (pin_count[i] == 0)
					free_at = i;
			end
			if (hit_at >= 0) begin
				if (pin_count[hit_at] >= PIN_MAX_DEF) begin
					r = make_result(hit_at, STAT_SAT, 1'b1, 1'b0);
				end else begin
					if (pin_count[hit_at] == 0)
						unpinned--;
					pin_count[hit_at]++;
					r = make_result(hit_at, STAT_OK, 1'b1, 1'b0);
				end
			end else if (free_at < 0) begin
				r = make_result(0, STAT_FULL, 1'b0, 1'b0);
			end else begin
				held[free_at]      = 1'b1;
				held_tag[free_at]  = tag;
				pin_count[free_at] = 1;
				unpinned--;
				r = make_result(free_at, STAT_OK, 1'b0, 1'b1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pin_result_t got;
		pin_result_t want;
		int          bad;
		bad = 0;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
				held[i]      = 1'b0;
				held_tag[i]  = '0;
				pin_count[i] = 0;
			end
			unpinned = NUM_SLOTS_DEF;
			expected_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.slot       = m_tdata[0 +: SLOT_FIELD_W];
				got.status     = bpm_status_t'(m_tdata[STAT_LSB +: STAT_W]);
				got.hit        = m_tdata[HIT_LSB];
				got.needs_load = m_tdata[LOAD_LSB];
				got.avail      = m_tdata[AVAIL_LSB +: AVAIL_W];
				if (expected_q.size() == 0) begin
					$error("result transfer with no request outstanding");
					bad++;
				end else begin
					want = expected_q.pop_front();
					if (got.slot !== want.slot) begin
						$error("slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
						bad++;
					end
					if (got.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, got.status);
						bad++;
					end
					if (got.hit !== want.hit) begin
						$error("hit mismatch: expected %0d, actual %0d", want.hit, got.hit);
						bad++;
					end
					if (got.needs_load !== want.needs_load) begin
						$error("needs_load mismatch: expected %0d, actual %0d",
							want.needs_load, got.needs_load);
						bad++;
					end
					if (got.avail !== want.avail) begin
						$error("available_count mismatch: expected %0d, actual %0d",
							want.avail, got.avail);
						bad++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_request(bpm_func_t'(s_tuser), s_tdata[0 +: TAG_FIELD_W],
					s_tdata[TAG_FIELD_W +: IDX_FIELD_W], want);
				expected_q.push_back(want);
			end
			pending    <= expected_q.size();
			fail_count <= fail_count + bad;
		end
	end

endmodule

// ----- tb/buffer_pool_pin_manager_core_test.sv -----
// ----------------------------------------------------------------------------
// buffer_pool_pin_manager_core_test
// directed and random pin/unpin traffic with random stalls on both channels,
// a full drain, a saturation run on one slot and a long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buffer_pool_pin_manager_core_test;
	import bpm_pkg::*;

	localparam int POOL_TAGS = 12;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // block_tag, slot_index, zero pad
	logic                 s_tuser;   // func
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // slot, status, hit, needs_load, available_count, pad

	int                   fail_count;
	int                   pending;
	int                   sent;
	bit                   hold_req;
	bit                   hold_done;
	bit                   send_burst;
	logic [2:0]           last_slot;
	bpm_status_t          last_status;
	logic [TAG_FIELD_W-1:0] tag_pool[POOL_TAGS];

	buffer_pool_pin_manager_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bpm_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// last result seen, used to steer the drain and saturation runs
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			last_slot   <= m_tdata[0 +: SLOT_FIELD_W];
			last_status <= bpm_status_t'(m_tdata[SLOT_FIELD_W +: STAT_W]);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [TAG_FIELD_W-1:0] rand_tag();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TAG_FIELD_W-1:0];
	endfunction

	task automatic transfer(input bpm_func_t op, input logic [TAG_FIELD_W-1:0] tag,
			input logic [IDX_FIELD_W-1:0] idx);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_TDATA_W - TAG_FIELD_W - IDX_FIELD_W){1'b0}}, idx, tag};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		gap = send_burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic pin(input logic [TAG_FIELD_W-1:0] tag);
		transfer(FUNC_PIN, tag, IDX_FIELD_W'($urandom_range(0, 7)));
	endtask

	task automatic unpin(input logic [IDX_FIELD_W-1:0] idx);
		transfer(FUNC_UNPIN, rand_tag(), idx);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// mostly pool tags so pins hit and slots fill, some fresh tags as noise
	task automatic random_chunk();
		int len;
		int pin_pct;
		len = $urandom_range(20, 80);
		case ($urandom_range(0, 3))
			0: pin_pct = 25;
			1: pin_pct = 50;
			2: pin_pct = 75;
			default: pin_pct = 92;
		endcase
		send_burst = ($urandom_range(0, 5) == 0);
		repeat (len) begin
			if ($urandom_range(0, 99) < pin_pct) begin
				if ($urandom_range(0, 9) == 0)
					pin(rand_tag());
				else
					pin(tag_pool[$urandom_range(0, POOL_TAGS - 1)]);
			end else begin
				unpin(IDX_FIELD_W'($urandom_range(0, 7)));
			end
		end
		send_burst = 1'b0;
	endtask

	initial begin
		int run;
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				// hold the output long enough for the input side to back up
				repeat (30) @(posedge clk);
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 12);
				m_tready <= 1'b1;
				repeat (run) @(posedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int s;
		logic [TAG_FIELD_W-1:0] sat_tag;
		logic [2:0] sat_slot;
		s_tvalid   <= 1'b0;
		s_tuser    <= FUNC_PIN;
		s_tdata    <= '0;
		arst_n     <= 1'b0;
		hold_req   = 1'b0;
		hold_done  = 1'b0;
		send_burst = 1'b0;
		sent       = 0;
		// a few pool tags differ from the first in a single bit
		tag_pool[0] = rand_tag();
		for (int i = 1; i < 5; i++)
			tag_pool[i] = tag_pool[0] ^ ({{(TAG_FIELD_W-1){1'b0}}, 1'b1} << $urandom_range(0, 47));
		for (int i = 5; i < POOL_TAGS; i++)
			tag_pool[i] = rand_tag();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pin(48'h0000_0000_0000);
		pin(48'hFFFF_FFFF_FFFF);
		pin(48'h0000_0000_0000);
		unpin(3'd7);
		unpin(3'd0);
		unpin(3'd0);
		unpin(3'd0);
		// released slot keeps its tag
		pin(48'h0000_0000_0000);
		for (int t = 2; t < 8; t++)
			pin(48'h8000_0000_0000 >> t);
		pin(48'h5555_5555_5555);
		pin(48'hFFFF_FFFF_FFFF);
		unpin(3'd1);
		pin(48'hAAAA_AAAA_AAAA);

		hold_req = 1'b1;
		while (sent < 700)
			random_chunk();

		// release every slot one transfer at a time
		settle();
		for (s = 0; s < NUM_SLOTS_DEF; s++) begin
			do begin
				unpin(IDX_FIELD_W'(s));
				settle();
			end while (last_status != STAT_NOT_PIN);
		end

		// drive one slot to the pin limit and back down past zero
		sat_tag = rand_tag();
		repeat (PIN_MAX_DEF + 3) pin(sat_tag);
		settle();
		sat_slot = last_slot;
		repeat (PIN_MAX_DEF + 1) unpin(sat_slot);

		while (sent < 1850)
			random_chunk();
		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bpm_pkg.sv
rtl/bpm_cell.sv
rtl/buffer_pool_pin_manager_core.sv
tb/bpm_result_checker.sv
tb/buffer_pool_pin_manager_core_test.sv
